>>> design/tpd_pkg.sv
`timescale 1ns / 1ps

package tpd_pkg;

    // Fixed-point format of positions, gains and times
    localparam int FRAC_BITS = 16;

    localparam int MUL_A_W   = 51;   // signed multiplicand into the shared multiplier
    localparam int MUL_MAG_W = 50;   // its magnitude
    localparam int MUL_G_W   = 32;   // unsigned multiplier word
    localparam int MUL_ACC_W = MUL_MAG_W + MUL_G_W;
    localparam int MUL_RES_W = 52;   // signed, limited product
    localparam int DIGIT_W   = 4;    // multiplier bits retired per cycle
    localparam int DIGITS    = MUL_G_W / DIGIT_W;

    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 33;

    localparam logic [MUL_ACC_W-FRAC_BITS-1:0] PROD_LIMIT =
        (MUL_ACC_W-FRAC_BITS)'(1) << 50;

    localparam logic [DIV_NUM_W-1:0] NUM_PERIOD = DIV_NUM_W'(500000) << FRAC_BITS;

    localparam logic [16:0] BLEND_ONE   = 17'(1) << FRAC_BITS;
    localparam logic [30:0] GAIN_P_RST  = 31'(10) << FRAC_BITS;
    localparam logic [30:0] GAIN_I_RST  = 31'(50) << FRAC_BITS;
    localparam logic [30:0] GAIN_D_RST  = 31'(1) << (FRAC_BITS - 1);
    localparam logic [16:0] BLEND_RST   = 17'((2 << FRAC_BITS) / 5);
    localparam logic [30:0] SPEED_RST   = 31'(1) << FRAC_BITS;

    localparam int SENSOR_SHIFT = 22 - FRAC_BITS;
    localparam logic signed [63:0] SENSOR_MUL = 64'sd1638;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] S48_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam logic signed [63:0] S48_MIN = -(64'sd1 <<< 47);

    // Configuration register indexes
    localparam logic [2:0] REG_OFFSET_X = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z = 3'd2;
    localparam logic [2:0] REG_GAIN_P   = 3'd3;
    localparam logic [2:0] REG_GAIN_I   = 3'd4;
    localparam logic [2:0] REG_GAIN_D   = 3'd5;
    localparam logic [2:0] REG_BLEND    = 3'd6;
    localparam logic [2:0] REG_MAXSPEED = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GLITCH,
        ST_PRED,
        ST_BLEND,
        ST_INTEG,
        ST_DERIV,
        ST_PROP,
        ST_INTG_G,
        ST_DERV_G,
        ST_MOTOR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                        start;
        logic signed [MUL_A_W-1:0]   a;
        logic [MUL_G_W-1:0]          g;
    } mul_req_t;

    typedef struct packed {
        logic                        start;
        logic [DIV_NUM_W-1:0]        num;
        logic [DIV_DEN_W-1:0]        den;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX)
            return 32'sh7FFFFFFF;
        else if (v < S32_MIN)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > S48_MAX)
            return S48_MAX[47:0];
        else if (v < S48_MIN)
            return S48_MIN[47:0];
        else
            return v[47:0];
    endfunction

    // raw * 1638 * 2^F / 2^22 rounded down, minus offset, saturated
    function automatic logic signed [31:0] scale_sensor(input logic signed [15:0] raw,
                                                        input logic signed [31:0] offs);
        logic signed [63:0] prod;
        prod = (64'(raw) * SENSOR_MUL) >>> SENSOR_SHIFT;
        return sat32(prod - 64'(offs));
    endfunction

endpackage

>>> design/tpd_mul.sv
`timescale 1ns / 1ps

// Shared multiplier: sign(a) * min(trunc(|a| * g / 2^F), 2^50).
// Four multiplier bits per cycle, then a final step shifts and limits the product.
module tpd_mul
    import tpd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mul_req_t                    req,
    output logic                        done,
    output logic signed [MUL_RES_W-1:0] result
);

    logic                       busy_reg, busy_next;
    logic [3:0]                 cnt_reg, cnt_next;
    logic [MUL_MAG_W-1:0]       m_reg, m_next;
    logic                       neg_reg, neg_next;
    logic [MUL_G_W-1:0]         g_reg, g_next;
    logic [MUL_ACC_W-1:0]       acc_reg, acc_next;
    logic                       done_reg, done_next;
    logic signed [MUL_RES_W-1:0] res_reg, res_next;

    logic [MUL_ACC_W-FRAC_BITS-1:0] shifted;
    logic [MUL_ACC_W-FRAC_BITS-1:0] limited;
    logic [MUL_A_W-1:0]             a_mag;

    assign shifted = acc_reg[MUL_ACC_W-1:FRAC_BITS];
    assign limited = (shifted > PROD_LIMIT) ? PROD_LIMIT : shifted;
    assign a_mag   = req.a[MUL_A_W-1] ? MUL_A_W'(-req.a) : MUL_A_W'(req.a);

    // Digit step and finish
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        neg_next  = neg_reg;
        g_next    = g_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            m_next    = a_mag[MUL_MAG_W-1:0];
            neg_next  = req.a[MUL_A_W-1];
            g_next    = req.g;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'(DIGITS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -$signed(MUL_RES_W'(limited))
                                    : $signed(MUL_RES_W'(limited));
            end
            else
            begin
                acc_next = (acc_reg << DIGIT_W)
                         + MUL_ACC_W'(m_reg) * g_reg[MUL_G_W-1 -: DIGIT_W];
                g_next   = g_reg << DIGIT_W;
                cnt_next = cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        neg_reg <= neg_next;
        g_reg   <= g_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> design/tpd_div.sv
`timescale 1ns / 1ps

// Shared unsigned restoring divider, one quotient bit per cycle.
module tpd_div
    import tpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    logic                   busy_reg, busy_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [DIV_DEN_W:0]     rem_reg, rem_next;
    logic [DIV_NUM_W-1:0]   num_reg, num_next;
    logic [DIV_DEN_W-1:0]   den_reg, den_next;
    logic                   done_reg, done_next;

    logic [DIV_DEN_W:0]     trial;
    logic                   fits;

    assign trial = {rem_reg[DIV_DEN_W-1:0], num_reg[DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial - {1'b0, den_reg} : trial;
            num_next = {num_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

>>> design/three_axis_filtered_pid_drive_top.sv
`timescale 1ns / 1ps

// Three-axis filtered PID drive, one controller tick per input item.
// s_axis: one tick (raw sensors, setpoints, feed velocities, stamp) in tdata.
// m_axis: one result per tick; tuser holds the status bit (1 = bad data,
//   tick skipped), tdata the x direction, step period/duty, estimate and drive.
// cfg: register writes (index, data), always ready; write only while idle.
// Work: a good tick runs 19 products on the shared multiplier and 4 divisions
//   (three derivatives and the step period; the duty is half the period
//   quotient). A zero dt or zero speed skips that division. One tick is in
//   work at a time; s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; the next tick is accepted while it
//   waits, and a stalled receiver only holds that tick at its finish step.
// Reset clears estimates, drives, integrals and stamp, sets direction forward
//   and loads the default gains.
module three_axis_filtered_pid_drive_top
    import tpd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // raw_x, raw_y, raw_z, target_x/y/z, feed_x/y/z, stamp
    input  logic [271:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // direction, direction_changed, step_period, step_duty, estimate_x, drive_x, zero pad
    output logic [135:0]  m_axis_tdata,
    // status
    output logic          m_axis_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    state_t state_reg, state_next;

    // configuration
    logic signed [31:0] offset_reg [3];
    logic [30:0] gain_p_reg, gain_i_reg, gain_d_reg, max_speed_reg;
    logic [16:0] blend_reg;

    // latched tick
    logic signed [15:0] raw_reg    [3], raw_next    [3];
    logic signed [31:0] target_reg [3], target_next [3];
    logic signed [31:0] feed_reg   [3], feed_next   [3];
    logic [31:0] dt_reg, dt_next, prev_stamp_reg, prev_stamp_next;

    // controller state
    logic signed [31:0] est_reg   [3], est_next   [3];
    logic signed [31:0] drv_reg   [3], drv_next   [3];
    logic signed [31:0] perr_reg  [3], perr_next  [3];
    logic signed [47:0] integ_reg [3], integ_next [3];
    logic dir_reg, dir_next;

    // working registers
    logic [1:0] axis_reg, axis_next;
    logic issued_reg, issued_next;
    logic bad_reg, bad_next;
    logic dneg_reg, dneg_next;
    logic chg_reg, chg_next;
    logic signed [31:0] pred_reg, pred_next, err_reg, err_next;
    logic signed [49:0] deriv_reg, deriv_next;
    logic signed [53:0] acc_reg, acc_next;
    logic [31:0] period_reg, period_next, duty_reg, duty_next;

    // output register
    logic out_valid_reg, out_valid_next;
    logic [135:0] out_data_reg, out_data_next;
    logic out_user_reg, out_user_next;

    mul_req_t mul_req;
    div_req_t div_req;
    logic mul_done, div_done;
    logic signed [MUL_RES_W-1:0] mul_res;
    logic [DIV_NUM_W-1:0] div_quot;

    logic in_fire, out_free;
    logic signed [31:0] sensor_cur;
    logic signed [33:0] glitch_diff;
    logic [33:0] glitch_mag;
    logic glitch_bad;
    logic [16:0] blend_eff;
    logic signed [33:0] motor_v;
    logic [32:0] speed;
    logic signed [63:0] diff64;
    logic [63:0] dmag64;

    tpd_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .done   (mul_done),
        .result (mul_res)
    );

    tpd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    // shared terms
    assign sensor_cur  = scale_sensor(raw_reg[axis_reg], offset_reg[axis_reg]);
    assign glitch_diff = 34'(sensor_cur) - 34'(est_reg[0]);
    assign glitch_mag  = glitch_diff[33] ? 34'(-glitch_diff) : 34'(glitch_diff);
    assign glitch_bad  = $signed({18'd0, glitch_mag}) > mul_res;
    assign blend_eff   = (blend_reg > BLEND_ONE) ? BLEND_ONE : blend_reg;
    assign motor_v     = -34'(feed_reg[0]) - 34'(drv_reg[0]);
    assign speed       = motor_v[33] ? 33'(-motor_v) : 33'(motor_v);
    assign diff64      = 64'(err_reg) - 64'(perr_reg[axis_reg]);
    assign dmag64      = diff64[63] ? 64'(-diff64) : 64'(diff64);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_GLITCH;
            ST_GLITCH:
                if (issued_reg && mul_done)
                    state_next = glitch_bad ? ST_FINISH : ST_PRED;
            ST_PRED:
                if (issued_reg && mul_done)
                    state_next = ST_BLEND;
            ST_BLEND:
                if (issued_reg && mul_done)
                    state_next = ST_INTEG;
            ST_INTEG:
                if (issued_reg && mul_done)
                    state_next = ST_DERIV;
            ST_DERIV:
                if (dt_reg == '0 || (issued_reg && div_done))
                    state_next = ST_PROP;
            ST_PROP:
                if (issued_reg && mul_done)
                    state_next = ST_INTG_G;
            ST_INTG_G:
                if (issued_reg && mul_done)
                    state_next = ST_DERV_G;
            ST_DERV_G:
                if (issued_reg && mul_done)
                    state_next = (axis_reg == 2'd2) ? ST_MOTOR : ST_PRED;
            ST_MOTOR:
                if (speed == '0 || (issued_reg && div_done))
                    state_next = ST_FINISH;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and unit requests
    always_comb
    begin
        raw_next        = raw_reg;
        target_next     = target_reg;
        feed_next       = feed_reg;
        dt_next         = dt_reg;
        prev_stamp_next = prev_stamp_reg;
        est_next        = est_reg;
        drv_next        = drv_reg;
        perr_next       = perr_reg;
        integ_next      = integ_reg;
        dir_next        = dir_reg;
        axis_next       = axis_reg;
        issued_next     = issued_reg;
        bad_next        = bad_reg;
        dneg_next       = dneg_reg;
        chg_next        = chg_reg;
        pred_next       = pred_reg;
        err_next        = err_reg;
        deriv_next      = deriv_reg;
        acc_next        = acc_reg;
        period_next     = period_reg;
        duty_next       = duty_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        mul_req         = '0;
        div_req         = '0;

        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        raw_next[i]    = s_axis_tdata[16*i +: 16];
                        target_next[i] = s_axis_tdata[48 + 32*i +: 32];
                        feed_next[i]   = s_axis_tdata[144 + 32*i +: 32];
                    end
                    dt_next         = s_axis_tdata[271:240] - prev_stamp_reg;
                    prev_stamp_next = s_axis_tdata[271:240];
                    axis_next       = '0;
                    issued_next     = 1'b0;
                    bad_next        = 1'b0;
                end
            ST_GLITCH:
                // max_speed * dt / 2^F against the magnitude of the x sensor minus the x estimate
                if (!issued_reg)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'($signed({1'b0, dt_reg}));
                    mul_req.g     = {1'b0, max_speed_reg};
                    issued_next   = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    if (glitch_bad)
                    begin
                        bad_next    = 1'b1;
                        chg_next    = 1'b0;
                        period_next = '0;
                        duty_next   = '0;
                    end
                end
            ST_PRED:
                if (!issued_reg)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(sat32(64'(feed_reg[axis_reg])
                                                   + 64'(drv_reg[axis_reg])));
                    mul_req.g     = dt_reg;
                    issued_next   = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    pred_next   = sat32(64'(est_reg[axis_reg]) + 64'(mul_res));
                end
            ST_BLEND:
                if (!issued_reg)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(64'(sensor_cur) - 64'(pred_reg));
                    mul_req.g     = MUL_G_W'(blend_eff);
                    issued_next   = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next        = 1'b0;
                    est_next[axis_reg] = sat32(64'(pred_reg) + 64'(mul_res));
                    err_next           = sat32(64'(target_reg[axis_reg])
                                               - 64'(est_next[axis_reg]));
                end
            ST_INTEG:
                if (!issued_reg)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(err_reg);
                    mul_req.g     = dt_reg;
                    issued_next   = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next          = 1'b0;
                    integ_next[axis_reg] = sat48(64'(integ_reg[axis_reg]) + 64'(mul_res));
                end
            ST_DERIV:
                // (err - prev_err) * 2^F / dt, truncated toward zero
                if (dt_reg == '0)
                begin
                    deriv_next          = '0;
                    perr_next[axis_reg] = err_reg;
                end
                else if (!issued_reg)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NUM_W'(dmag64 << FRAC_BITS);
                    div_req.den   = {1'b0, dt_reg};
                    dneg_next     = diff64[63];
                    issued_next   = 1'b1;
                end
                else if (div_done)
                begin
                    issued_next         = 1'b0;
                    deriv_next          = dneg_reg ? -$signed(div_quot) : $signed(div_quot);
                    perr_next[axis_reg] = err_reg;
                end
            ST_PROP:
                if (!issued_reg)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(err_reg);
                    mul_req.g     = {1'b0, gain_p_reg};
                    issued_next   = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    acc_next    = 54'(mul_res);
                end
            ST_INTG_G:
                if (!issued_reg)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(integ_reg[axis_reg]);
                    mul_req.g     = {1'b0, gain_i_reg};
                    issued_next   = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    acc_next    = acc_reg + 54'(mul_res);
                end
            ST_DERV_G:
                if (!issued_reg)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(deriv_reg);
                    mul_req.g     = {1'b0, gain_d_reg};
                    issued_next   = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next        = 1'b0;
                    drv_next[axis_reg] = sat32(64'(acc_reg) + 64'(mul_res));
                    if (axis_reg != 2'd2)
                        axis_next = axis_reg + 2'd1;
                end
            ST_MOTOR:
                // period from one divide, duty is half that quotient
                if (speed == '0)
                begin
                    period_next = '1;
                    duty_next   = '1;
                    chg_next    = (!motor_v[33]) != dir_reg;
                    dir_next    = !motor_v[33];
                end
                else if (!issued_reg)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_PERIOD;
                    div_req.den   = speed;
                    issued_next   = 1'b1;
                end
                else if (div_done)
                begin
                    issued_next = 1'b0;
                    period_next = (div_quot > DIV_NUM_W'(32'hFFFFFFFF)) ? '1 : div_quot[31:0];
                    duty_next   = ((div_quot >> 1) > DIV_NUM_W'(32'hFFFFFFFF))
                                  ? '1 : div_quot[32:1];
                    chg_next    = (!motor_v[33]) != dir_reg;
                    dir_next    = !motor_v[33];
                end
            ST_FINISH:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = bad_reg;
                    out_data_next  = {6'd0, drv_reg[0], est_reg[0], duty_reg, period_reg,
                                      chg_reg, dir_reg};
                end
            default:
            begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
            offset_reg[2] <= '0;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            blend_reg     <= BLEND_RST;
            max_speed_reg <= SPEED_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OFFSET_X: offset_reg[0] <= cfg_data;
                REG_OFFSET_Y: offset_reg[1] <= cfg_data;
                REG_OFFSET_Z: offset_reg[2] <= cfg_data;
                REG_GAIN_P:   gain_p_reg    <= cfg_data[30:0];
                REG_GAIN_I:   gain_i_reg    <= cfg_data[30:0];
                REG_GAIN_D:   gain_d_reg    <= cfg_data[30:0];
                REG_BLEND:    blend_reg     <= cfg_data[16:0];
                REG_MAXSPEED: max_speed_reg <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    // control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_stamp_reg <= '0;
            dir_reg        <= 1'b1;
            axis_reg       <= '0;
            issued_reg     <= 1'b0;
            bad_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                est_reg[i]   <= '0;
                drv_reg[i]   <= '0;
                perr_reg[i]  <= '0;
                integ_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            prev_stamp_reg <= prev_stamp_next;
            dir_reg        <= dir_next;
            axis_reg       <= axis_next;
            issued_reg     <= issued_next;
            bad_reg        <= bad_next;
            out_valid_reg  <= out_valid_next;
            est_reg        <= est_next;
            drv_reg        <= drv_next;
            perr_reg       <= perr_next;
            integ_reg      <= integ_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        raw_reg      <= raw_next;
        target_reg   <= target_next;
        feed_reg     <= feed_next;
        dt_reg       <= dt_next;
        dneg_reg     <= dneg_next;
        chg_reg      <= chg_next;
        pred_reg     <= pred_next;
        err_reg      <= err_next;
        deriv_reg    <= deriv_next;
        acc_reg      <= acc_next;
        period_reg   <= period_next;
        duty_reg     <= duty_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
